// ----- hw/rtl/pcf_pkg.sv -----
`timescale 1ns / 1ps

package pcf_pkg;

	localparam int unsigned STEP_W = 5;

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [16:0] K_055   = 17'd36045;
	localparam logic [16:0] K_045   = 17'd29491;
	localparam logic [16:0] K_085   = 17'd55706;
	localparam logic [16:0] K_072   = 17'd47186;
	localparam logic [16:0] K_092   = 17'd60293;
	localparam logic [16:0] K_035   = 17'd22938;
	localparam logic [16:0] K_065   = 17'd42598;
	localparam logic [16:0] K_025   = 17'd16384;
	localparam logic [16:0] K_020   = 17'd13107;
	localparam logic [16:0] K_022   = 17'd14418;
	localparam logic [16:0] K_058   = 17'd38011;
	localparam logic [16:0] K_080   = 17'd52429;
	localparam logic [16:0] K_050   = 17'd32768;

	localparam logic [1:0] NAV_NOMINAL  = 2'd0;
	localparam logic [1:0] NAV_DEGRADED = 2'd1;
	localparam logic [1:0] NAV_LOST     = 2'd2;

	localparam logic [2:0] SRC_TDOA_RECOVERY = 3'd0;
	localparam logic [2:0] SRC_VIO_TDOA      = 3'd1;
	localparam logic [2:0] SRC_IMU_DR        = 3'd2;
	localparam logic [2:0] SRC_VISION_DEPTH  = 3'd3;
	localparam logic [2:0] SRC_VISION_INERT  = 3'd4;

	localparam int unsigned FLAG_RADIO  = 0;
	localparam int unsigned FLAG_CAMERA = 1;
	localparam int unsigned FLAG_LIDAR  = 2;
	localparam int unsigned FLAG_RANGE  = 3;
	localparam int unsigned FLAG_SYNC   = 4;

	typedef enum logic [3:0] {
		A_NONE, A_DIFFX, A_DIFFY, A_DIFFZ, A_DIFFC,
		A_RC, A_DB, A_CONF, A_AR, A_SC
	} asel_t;

	typedef enum logic [3:0] {
		B_NONE, B_W, B_K055, B_K045, B_K072, B_K092,
		B_SCMAX, B_ANCH, B_K035, B_K025, B_K020
	} bsel_t;

	typedef enum logic [3:0] {
		WB_NONE, WB_ACC_LD, WB_ACC_ADD, WB_W, WB_FX, WB_FY, WB_FZ,
		WB_CMAX, WB_CONF, WB_ANCH, WB_FLOOR
	} wb_t;

	typedef enum logic [2:0] {
		C_NEVER, C_NO_RADIO, C_CAMERA, C_DEPTH, C_SYNCED, C_NO_FLOOR
	} cond_t;

	typedef struct packed {
		asel_t             asel;
		bsel_t             bsel;
		wb_t               wb;
		cond_t             jcond;
		logic [STEP_W-1:0] jtgt;
		logic              last;
	} cw_t;

	typedef struct packed {
		logic no_radio;
		logic camera;
		logic depth;
		logic synced;
		logic no_floor;
	} cond_flags_t;

	function automatic logic [16:0] sat_one(input logic [16:0] v);
		return (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

	function automatic cw_t mk(input asel_t a, input bsel_t b, input wb_t wb,
			input cond_t c, input logic [STEP_W-1:0] t, input logic l);
		cw_t cw;
		cw.asel  = a;
		cw.bsel  = b;
		cw.wb    = wb;
		cw.jcond = c;
		cw.jtgt  = t;
		cw.last  = l;
		return cw;
	endfunction

	// each word issues one product; the next word writes it back
	function automatic cw_t ucode(input logic [STEP_W-1:0] step);
		cw_t cw;
		unique case (step)
			5'd0:    cw = mk(A_RC,    B_K055,  WB_NONE,    C_NO_RADIO, 5'd8,  1'b0);
			5'd1:    cw = mk(A_DB,    B_K045,  WB_ACC_LD,  C_NEVER,    5'd0,  1'b0);
			5'd2:    cw = mk(A_NONE,  B_NONE,  WB_W,       C_NEVER,    5'd0,  1'b0);
			5'd3:    cw = mk(A_DIFFX, B_W,     WB_NONE,    C_NEVER,    5'd0,  1'b0);
			5'd4:    cw = mk(A_DIFFY, B_W,     WB_FX,      C_NEVER,    5'd0,  1'b0);
			5'd5:    cw = mk(A_DIFFZ, B_W,     WB_FY,      C_NEVER,    5'd0,  1'b0);
			5'd6:    cw = mk(A_DIFFC, B_W,     WB_FZ,      C_NEVER,    5'd0,  1'b0);
			5'd7:    cw = mk(A_NONE,  B_NONE,  WB_CMAX,    C_NEVER,    5'd0,  1'b0);
			5'd8:    cw = mk(A_CONF,  B_K072,  WB_NONE,    C_CAMERA,   5'd10, 1'b0);
			5'd9:    cw = mk(A_NONE,  B_NONE,  WB_CONF,    C_NEVER,    5'd0,  1'b0);
			5'd10:   cw = mk(A_CONF,  B_K092,  WB_NONE,    C_DEPTH,    5'd12, 1'b0);
			5'd11:   cw = mk(A_NONE,  B_NONE,  WB_CONF,    C_NEVER,    5'd0,  1'b0);
			5'd12:   cw = mk(A_CONF,  B_SCMAX, WB_NONE,    C_SYNCED,   5'd14, 1'b0);
			5'd13:   cw = mk(A_NONE,  B_NONE,  WB_CONF,    C_NEVER,    5'd0,  1'b0);
			5'd14:   cw = mk(A_AR,    B_K035,  WB_NONE,    C_NEVER,    5'd0,  1'b0);
			5'd15:   cw = mk(A_NONE,  B_NONE,  WB_ANCH,    C_NEVER,    5'd0,  1'b0);
			5'd16:   cw = mk(A_CONF,  B_ANCH,  WB_NONE,    C_NEVER,    5'd0,  1'b0);
			5'd17:   cw = mk(A_RC,    B_K055,  WB_CONF,    C_NO_FLOOR, 5'd21, 1'b0);
			5'd18:   cw = mk(A_AR,    B_K025,  WB_ACC_LD,  C_NEVER,    5'd0,  1'b0);
			5'd19:   cw = mk(A_SC,    B_K020,  WB_ACC_ADD, C_NEVER,    5'd0,  1'b0);
			5'd20:   cw = mk(A_NONE,  B_NONE,  WB_FLOOR,   C_NEVER,    5'd0,  1'b0);
			default: cw = mk(A_NONE,  B_NONE,  WB_NONE,    C_NEVER,    5'd0,  1'b1);
		endcase
		return cw;
	endfunction

endpackage

// ----- hw/rtl/pcf_in_if.sv -----
`timescale 1ns / 1ps

interface pcf_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vio_x;
	logic signed [31:0] vio_y;
	logic signed [31:0] vio_z;
	logic [16:0]        vio_confidence;
	logic [15:0]        vio_drift;
	logic signed [31:0] radio_x;
	logic signed [31:0] radio_y;
	logic signed [31:0] radio_z;
	logic [16:0]        radio_confidence;
	logic [4:0]         status_flags;
	logic [16:0]        sync_confidence;
	logic [16:0]        anchor_ratio;

	modport source (
		output valid, vio_x, vio_y, vio_z, vio_confidence, vio_drift,
		       radio_x, radio_y, radio_z, radio_confidence, status_flags,
		       sync_confidence, anchor_ratio,
		input  ready
	);

	modport sink (
		input  valid, vio_x, vio_y, vio_z, vio_confidence, vio_drift,
		       radio_x, radio_y, radio_z, radio_confidence, status_flags,
		       sync_confidence, anchor_ratio,
		output ready
	);
endinterface

// ----- hw/rtl/pcf_out_if.sv -----
`timescale 1ns / 1ps

interface pcf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] fused_x;
	logic signed [31:0] fused_y;
	logic signed [31:0] fused_z;
	logic [15:0]        radio_weight;
	logic [16:0]        fused_confidence;
	logic signed [17:0] confidence_change;
	logic [1:0]         nav_state;
	logic [2:0]         source_code;

	modport source (
		output valid, fused_x, fused_y, fused_z, radio_weight, fused_confidence,
		       confidence_change, nav_state, source_code,
		input  ready
	);

	modport sink (
		input  valid, fused_x, fused_y, fused_z, radio_weight, fused_confidence,
		       confidence_change, nav_state, source_code,
		output ready
	);
endinterface

// ----- hw/rtl/pcf_seq.sv -----
`timescale 1ns / 1ps

module pcf_seq
	import pcf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        hold,
	input  cond_flags_t cond,
	output cw_t         cw,
	output logic        busy,
	output logic        done
);

	logic [STEP_W-1:0] pc_q;
	logic              busy_q;
	logic              take;

	assign cw   = ucode(pc_q);
	assign busy = busy_q;
	assign done = busy_q && cw.last && !hold;

	always_comb begin
		unique case (cw.jcond)
			C_NEVER:    take = 1'b0;
			C_NO_RADIO: take = cond.no_radio;
			C_CAMERA:   take = cond.camera;
			C_DEPTH:    take = cond.depth;
			C_SYNCED:   take = cond.synced;
			C_NO_FLOOR: take = cond.no_floor;
			default:    take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			pc_q   <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (cw.last) begin
				if (!hold) begin
					busy_q <= 1'b0;
				end
			end else if (take) begin
				pc_q <= cw.jtgt;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/position_confidence_fusion.sv -----
`timescale 1ns / 1ps

// position and confidence fusion of a visual-inertial pose with a tdoa pose
// req: one beat per pose update, carrying both positions, confidences,
//   drift, sensor flags, sync confidence and anchor visibility
// rsp: one beat per request: fused position, radio weight, confidence,
//   its change from the previous beat, navigation state and source code
// with the radio flag clear the sequencer skips the blend and radio floor
//   steps; with it set it runs the blend and, when enabled, the floor; the
//   camera, depth and sync penalty steps are skipped when their flags are set
// a microcoded step counter runs the work through a single 33x18
//   multiplier, one product per step
// req.ready is high while no beat is in work; a finished result sits in
//   the rsp register, so the next request is taken while it waits
// when rsp stalls with a result still held, the sequencer waits on its
//   last step until that register frees
// reset clears the sequencer, the rsp valid and the stored previous
//   confidence (to zero); nothing is in flight after reset
module position_confidence_fusion
	import pcf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	pcf_in_if.sink    req,
	pcf_out_if.source rsp
);

	logic signed [31:0] vx_q, vy_q, vz_q, rx_q, ry_q, rz_q;
	logic [16:0]        vc_q, rc_q, sc_q, ar_q;
	logic [15:0]        drift_q;
	logic [4:0]         flags_q;

	logic [15:0]        w_q;
	logic [16:0]        conf_q, acc_q, anch_q;
	logic signed [31:0] fx_q, fy_q, fz_q;
	logic signed [50:0] p_q;

	logic               out_valid_q;
	logic signed [31:0] ox_q, oy_q, oz_q;
	logic [15:0]        ow_q;
	logic [16:0]        oconf_q;
	logic signed [17:0] ochange_q;
	logic [1:0]         onav_q;
	logic [2:0]         osrc_q;
	logic [16:0]        prev_q;

	cw_t         cw;
	cond_flags_t cond;
	logic        busy, done, accept, hold;

	logic signed [32:0] a_op;
	logic signed [17:0] b_op;
	logic signed [17:0] diffc;
	logic [16:0]        db;
	logic signed [34:0] ph;
	logic [17:0]        acc_plus;
	logic [17:0]        anch_sum;
	logic signed [17:0] cblend;
	logic [16:0]        cfin;
	logic [1:0]         nav;
	logic [2:0]         src;
	logic               radio, camera, depth, floor_en;

	assign accept    = req.valid && req.ready;
	assign req.ready = !busy;
	assign hold      = out_valid_q && !rsp.ready;

	assign radio    = flags_q[FLAG_RADIO];
	assign camera   = flags_q[FLAG_CAMERA];
	assign depth    = flags_q[FLAG_LIDAR] || flags_q[FLAG_RANGE];
	assign floor_en = radio && (sc_q >= K_080) && (ar_q >= K_050);

	assign cond.no_radio = !radio;
	assign cond.camera   = camera;
	assign cond.depth    = depth;
	assign cond.synced   = flags_q[FLAG_SYNC];
	assign cond.no_floor = !floor_en;

	pcf_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.hold  (hold),
		.cond  (cond),
		.cw    (cw),
		.busy  (busy),
		.done  (done)
	);

	// operand selection
	assign diffc = 18'($signed({1'b0, rc_q})) - 18'($signed({1'b0, vc_q}));
	assign db    = (drift_q[15:9] != '0) ? ONE_Q16 : {1'b0, drift_q[8:0], 7'd0};

	always_comb begin
		case (cw.asel)
			A_DIFFX: a_op = 33'(rx_q) - 33'(vx_q);
			A_DIFFY: a_op = 33'(ry_q) - 33'(vy_q);
			A_DIFFZ: a_op = 33'(rz_q) - 33'(vz_q);
			A_DIFFC: a_op = 33'(diffc);
			A_RC:    a_op = {16'd0, rc_q};
			A_DB:    a_op = {16'd0, db};
			A_CONF:  a_op = {16'd0, conf_q};
			A_AR:    a_op = {16'd0, ar_q};
			A_SC:    a_op = {16'd0, sc_q};
			default: a_op = '0;
		endcase
	end

	always_comb begin
		case (cw.bsel)
			B_W:     b_op = {2'd0, w_q};
			B_K055:  b_op = {1'b0, K_055};
			B_K045:  b_op = {1'b0, K_045};
			B_K072:  b_op = {1'b0, K_072};
			B_K092:  b_op = {1'b0, K_092};
			B_SCMAX: b_op = {1'b0, (sc_q < K_035) ? K_035 : sc_q};
			B_ANCH:  b_op = {1'b0, anch_q};
			B_K035:  b_op = {1'b0, K_035};
			B_K025:  b_op = {1'b0, K_025};
			B_K020:  b_op = {1'b0, K_020};
			default: b_op = '0;
		endcase
	end

	// write-back arithmetic on the previous product, shifted by 16 (floor)
	assign ph       = p_q[50:16];
	assign acc_plus = {1'b0, acc_q} + ph[17:0];
	assign anch_sum = {1'b0, K_065} + ph[17:0];
	assign cblend   = $signed({1'b0, vc_q}) + $signed(ph[17:0]);

	// result formation
	assign cfin = sat_one(conf_q);

	always_comb begin
		if (cfin < K_022) begin
			nav = NAV_LOST;
		end else if (cfin < K_058) begin
			nav = NAV_DEGRADED;
		end else begin
			nav = NAV_NOMINAL;
		end
		if (nav == NAV_LOST && radio) begin
			src = SRC_TDOA_RECOVERY;
		end else if ({1'b0, w_q} > K_035 && radio) begin
			src = SRC_VIO_TDOA;
		end else if (!camera) begin
			src = SRC_IMU_DR;
		end else if (depth) begin
			src = SRC_VISION_DEPTH;
		end else begin
			src = SRC_VISION_INERT;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vx_q    <= req.vio_x;
			vy_q    <= req.vio_y;
			vz_q    <= req.vio_z;
			rx_q    <= req.radio_x;
			ry_q    <= req.radio_y;
			rz_q    <= req.radio_z;
			vc_q    <= sat_one(req.vio_confidence);
			rc_q    <= sat_one(req.radio_confidence);
			sc_q    <= sat_one(req.sync_confidence);
			ar_q    <= sat_one(req.anchor_ratio);
			drift_q <= req.vio_drift;
			flags_q <= req.status_flags;
			w_q     <= '0;
			conf_q  <= sat_one(req.vio_confidence);
			fx_q    <= req.vio_x;
			fy_q    <= req.vio_y;
			fz_q    <= req.vio_z;
		end else if (busy) begin
			p_q <= 51'(a_op) * 51'(b_op);
			case (cw.wb)
				WB_ACC_LD:  acc_q <= ph[16:0];
				WB_ACC_ADD: acc_q <= acc_plus[16:0];
				WB_W:       w_q <= (acc_plus > {1'b0, K_085}) ? K_085[15:0] : acc_plus[15:0];
				WB_FX:      fx_q <= vx_q + ph[31:0];
				WB_FY:      fy_q <= vy_q + ph[31:0];
				WB_FZ:      fz_q <= vz_q + ph[31:0];
				WB_CMAX: begin
					if (cblend[16:0] > conf_q) begin
						conf_q <= cblend[16:0];
					end
				end
				WB_CONF:    conf_q <= ph[16:0];
				WB_ANCH:    anch_q <= (anch_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : anch_sum[16:0];
				WB_FLOOR: begin
					if (acc_plus[16:0] > conf_q) begin
						conf_q <= acc_plus[16:0];
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (done) begin
			ox_q      <= fx_q;
			oy_q      <= fy_q;
			oz_q      <= fz_q;
			ow_q      <= w_q;
			oconf_q   <= cfin;
			ochange_q <= 18'($signed({1'b0, cfin})) - 18'($signed({1'b0, prev_q}));
			onav_q    <= nav;
			osrc_q    <= src;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			prev_q      <= '0;
		end else begin
			if (done) begin
				out_valid_q <= 1'b1;
				prev_q      <= cfin;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.fused_x           = ox_q;
	assign rsp.fused_y           = oy_q;
	assign rsp.fused_z           = oz_q;
	assign rsp.radio_weight      = ow_q;
	assign rsp.fused_confidence  = oconf_q;
	assign rsp.confidence_change = ochange_q;
	assign rsp.nav_state         = onav_q;
	assign rsp.source_code       = osrc_q;

endmodule
